// ===== sv/yuv2rgb_pkg.sv =====
// Shared types, constants and arithmetic helpers for the YUYV to RGB converter.
package yuv2rgb_pkg;

	// Payload of one input item: one YUYV word
	typedef struct packed {
		logic [7:0] luma_first;
		logic [7:0] chroma_blue;
		logic [7:0] luma_second;
		logic [7:0] chroma_red;
	} yuv2rgb_in_t;

	// Payload of one result item: two packed pixels
	typedef struct packed {
		logic [23:0] pixel_first;
		logic [23:0] pixel_second;
	} yuv2rgb_out_t;

	// Chroma contributions shared by both pixels of a word
	typedef struct packed {
		logic signed [8:0] red_v;    // floor(14075*v/10000), -181..178
		logic signed [7:0] green_u;  // trunc(3455*u/10000), -44..43
		logic signed [7:0] green_v;  // trunc(7169*v/10000), -91..91
		logic signed [8:0] blue_u;   // trunc(17790*u/10000), -227..225
	} yuv2rgb_chroma_t;

	// Conversion coefficients, scaled by CoefScale
	localparam int unsigned CoefRv    = 14075;
	localparam int unsigned CoefGu    = 3455;
	localparam int unsigned CoefGv    = 7169;
	localparam int unsigned CoefBu    = 17790;
	localparam int unsigned CoefScale = 10000;

	// Chroma magnitude is 0..128
	localparam int unsigned MagW = 8;
	// Reciprocal of CoefScale, rounded up; exact for products below 2^RecipShift / error
	localparam int unsigned RecipShift = 37;
	localparam longint unsigned RecipMul =
		((64'd1 << RecipShift) + 64'(CoefScale) - 64'd1) / 64'(CoefScale);
	localparam int unsigned KW    = 38;
	localparam int unsigned ProdW = KW + MagW;
	localparam int unsigned QuotW = ProdW - RecipShift;

	// Coefficient times reciprocal, folded into one constant each
	localparam logic [KW-1:0] KRv = KW'(64'(CoefRv) * RecipMul);
	localparam logic [KW-1:0] KGu = KW'(64'(CoefGu) * RecipMul);
	localparam logic [KW-1:0] KGv = KW'(64'(CoefGv) * RecipMul);
	localparam logic [KW-1:0] KBu = KW'(64'(CoefBu) * RecipMul);

	// Channel sum width: luma 0..255 plus a signed chroma term
	localparam int unsigned SumW = 11;

	// floor(coef * mag / CoefScale) by reciprocal multiplication
	function automatic logic [QuotW-1:0] scaled_floor(input logic [MagW-1:0] mag,
			input logic [KW-1:0] k);
		logic [ProdW-1:0] prod;
		prod = ProdW'(mag) * ProdW'(k);
		return prod[ProdW-1:RecipShift];
	endfunction

	// Saturate a signed channel sum to 0..255
	function automatic logic [7:0] clamp_channel(input logic signed [SumW-1:0] x);
		logic [7:0] res;
		if (x < 0) begin
			res = 8'd0;
		end else if (x > SumW'(255)) begin
			res = 8'd255;
		end else begin
			res = x[7:0];
		end
		return res;
	endfunction

endpackage

// ===== sv/yuv2rgb_chroma.sv =====
// Shared chroma stage: turns U and V into the four signed chroma terms, registered.
module yuv2rgb_chroma import yuv2rgb_pkg::*; (
	input  logic            clk,
	input  logic            en,
	input  logic [7:0]      chroma_blue,
	input  logic [7:0]      chroma_red,
	output yuv2rgb_chroma_t terms_s1
);

	logic                  u_neg, v_neg;
	logic [MagW-1:0]       u_twos, v_twos, u_mag, v_mag;
	logic [QuotW-1:0]      rv_q, gu_q, gv_q, bu_q;
	yuv2rgb_chroma_t       terms;

	// Offset-128 bytes become two's complement by flipping the top bit
	always_comb begin
		u_twos = {~chroma_blue[7], chroma_blue[6:0]};
		v_twos = {~chroma_red[7], chroma_red[6:0]};
		u_neg  = ~chroma_blue[7];
		v_neg  = ~chroma_red[7];
		u_mag  = u_neg ? MagW'(-u_twos) : u_twos;
		v_mag  = v_neg ? MagW'(-v_twos) : v_twos;
	end

	// Magnitude quotients
	always_comb begin
		rv_q = scaled_floor(v_mag, KRv);
		gu_q = scaled_floor(u_mag, KGu);
		gv_q = scaled_floor(v_mag, KGv);
		bu_q = scaled_floor(u_mag, KBu);
	end

	// Apply signs: truncation for G and B, floor for R.
	// 14075*|v| is never a multiple of 10000 for |v| in 1..128, so the
	// negative floor is one past the magnitude quotient.
	always_comb begin
		terms.green_u = u_neg ? -$signed(8'(gu_q)) : $signed(8'(gu_q));
		terms.green_v = v_neg ? -$signed(8'(gv_q)) : $signed(8'(gv_q));
		terms.blue_u  = u_neg ? -$signed(9'(bu_q)) : $signed(9'(bu_q));
		terms.red_v   = v_neg ? -$signed(9'(rv_q) + 9'sd1) : $signed(9'(rv_q));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			terms_s1 <= terms;
		end
	end

endmodule

// ===== sv/yuv2rgb_lane.sv =====
// One pixel lane: adds luma to the chroma terms, saturates and packs the pixel.
module yuv2rgb_lane import yuv2rgb_pkg::*; (
	input  logic            output_is_32bpp,
	input  logic [7:0]      luma,
	input  yuv2rgb_chroma_t terms,
	output logic [23:0]     pixel
);

	logic signed [SumW-1:0] y_ext, r_sum, g_sum, b_sum;
	logic [7:0]             r, g, b;

	// Channel sums
	always_comb begin
		y_ext = $signed({3'b000, luma});
		r_sum = y_ext + SumW'(terms.red_v);
		g_sum = y_ext - SumW'(terms.green_u) - SumW'(terms.green_v);
		b_sum = y_ext + SumW'(terms.blue_u);
		r     = clamp_channel(r_sum);
		g     = clamp_channel(g_sum);
		b     = clamp_channel(b_sum);
	end

	// RGB888 or RGB565 in the low 16 bits
	always_comb begin
		if (output_is_32bpp) begin
			pixel = {r, g, b};
		end else begin
			pixel = {8'd0, r[7:3], g[7:2], b[7:3]};
		end
	end

endmodule

// ===== sv/yuyv_to_rgb_pixel_converter_unit.sv =====
// Top level of the YUYV to RGB pixel converter.
// Converts one YUYV word (Y0, U, Y1, V) per cycle into two BT.601 pixels that
// share the chroma pair, packed as RGB888 or as RGB565 in the low 16 bits as
// selected by the mode register (reset value selects RGB888). One stage
// computes and registers the shared chroma terms, then two pixel lanes add
// luma, saturate and pack into the output register.
// A new item is taken every cycle unless the result side stalls; the mode
// register must only be written while no item is in flight.
module yuyv_to_rgb_pixel_converter_unit import yuv2rgb_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         yuyv_valid,
	output logic         yuyv_stall,
	input  yuv2rgb_in_t  yuyv,
	output logic         rgb_valid,
	input  logic         rgb_stall,
	output yuv2rgb_out_t rgb,
	input  logic         mode_we,
	input  logic         mode_wdata
);

	logic            output_is_32bpp_q;
	logic            valid_s1, valid_s2;
	logic            load_s1, load_s2, accept;
	logic [7:0]      luma_first_s1, luma_second_s1;
	yuv2rgb_chroma_t terms_s1;
	logic [23:0]     pix_first, pix_second;
	yuv2rgb_out_t    rgb_s2;

	// Mode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			output_is_32bpp_q <= 1'b1;
		end else if (mode_we) begin
			output_is_32bpp_q <= mode_wdata;
		end
	end

	// Pipeline flow: each stage loads when empty or when it is drained
	assign load_s2    = ~valid_s2 | ~rgb_stall;
	assign load_s1    = ~valid_s1 | load_s2;
	assign accept     = yuyv_valid & load_s1;
	assign yuyv_stall = ~load_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (load_s1) begin
				valid_s1 <= accept;
			end
			if (load_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// Stage 1: shared chroma terms and lumas
	yuv2rgb_chroma u_chroma (
		.clk         (clk),
		.en          (accept),
		.chroma_blue (yuyv.chroma_blue),
		.chroma_red  (yuyv.chroma_red),
		.terms_s1    (terms_s1)
	);

	always_ff @(posedge clk) begin
		if (accept) begin
			luma_first_s1  <= yuyv.luma_first;
			luma_second_s1 <= yuyv.luma_second;
		end
	end

	// Two pixel lanes
	yuv2rgb_lane u_lane_first (
		.output_is_32bpp (output_is_32bpp_q),
		.luma            (luma_first_s1),
		.terms           (terms_s1),
		.pixel           (pix_first)
	);

	yuv2rgb_lane u_lane_second (
		.output_is_32bpp (output_is_32bpp_q),
		.luma            (luma_second_s1),
		.terms           (terms_s1),
		.pixel           (pix_second)
	);

	// Stage 2: merge lanes into the output register
	always_ff @(posedge clk) begin
		if (load_s2 && valid_s1) begin
			rgb_s2.pixel_first  <= pix_first;
			rgb_s2.pixel_second <= pix_second;
		end
	end

	assign rgb_valid = valid_s2;
	assign rgb       = rgb_s2;

endmodule
